[hw/rtl/euler_angles_to_basis_vectors_macros.svh]
// assertion macros for the euler angles to basis vectors block
// used by the top level only, no other dependencies
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_MACROS_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_MACROS_SVH
`ifndef SYNTHESIS
`define EAB_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define EAB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EAB_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define EAB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[hw/rtl/eab_pkg.sv]
// shared types, constants and the cordic arctangent table
// no dependencies
`timescale 1ns / 1ps

package eab_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRONT_STAGES      = 3;
  localparam int BASIS_STAGES      = 6;
  localparam int FIXED_LATENCY     = FRONT_STAGES + BASIS_STAGES;

  localparam int NUM_ANGLES = 3;
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_ROLL  = 2;

  localparam int ANG_W   = 16;
  localparam int RED_W   = 15;
  localparam int QUO_W   = 9;
  localparam int REM_W   = 6;
  localparam int FRAC_W  = 23;
  localparam int BAM_W   = QUO_W + FRAC_W;
  localparam int RECIP_W = 2 * RED_W;
  localparam int XY_W    = 34;
  localparam int Z_W     = 33;
  localparam int TRIG_W  = 32;
  localparam int PROD_W  = 64;

  // 360 degrees in 1/64 degree units, split as 512 * 45
  localparam logic signed [ANG_W:0] TURN_UNITS = 17'sd23040;
  localparam logic [RED_W-1:0]      SUB_DIV    = 15'd45;
  localparam logic [RED_W-1:0]      RECIP_MUL  = 15'd23302;
  localparam int                    RECIP_SHIFT = 20;
  localparam logic [FRAC_W-1:0]     FRAC_STEP  = 23'd186413;

  localparam logic signed [XY_W-1:0]   INV_GAIN     = 34'sd652032874;
  localparam logic signed [Z_W-1:0]    QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [Z_W-1:0]    HALF_TURN    = 33'sd2147483648;
  localparam logic signed [TRIG_W-1:0] Q30_ONE      = 32'sd1073741824;

  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } lane_t;

  function automatic logic signed [Z_W-1:0] atan_at(input logic [4:0] idx);
    logic signed [Z_W-1:0] val;
    unique case (idx)
      5'd0:  val = 33'sd536870912;
      5'd1:  val = 33'sd316933406;
      5'd2:  val = 33'sd167458907;
      5'd3:  val = 33'sd85004756;
      5'd4:  val = 33'sd42667331;
      5'd5:  val = 33'sd21354465;
      5'd6:  val = 33'sd10679838;
      5'd7:  val = 33'sd5340245;
      5'd8:  val = 33'sd2670163;
      5'd9:  val = 33'sd1335087;
      5'd10: val = 33'sd667544;
      5'd11: val = 33'sd333772;
      5'd12: val = 33'sd166886;
      5'd13: val = 33'sd83443;
      5'd14: val = 33'sd41722;
      5'd15: val = 33'sd20861;
      5'd16: val = 33'sd10430;
      5'd17: val = 33'sd5215;
      5'd18: val = 33'sd2608;
      5'd19: val = 33'sd1304;
      5'd20: val = 33'sd652;
      5'd21: val = 33'sd326;
      5'd22: val = 33'sd163;
      5'd23: val = 33'sd81;
      5'd24: val = 33'sd41;
      5'd25: val = 33'sd20;
      5'd26: val = 33'sd10;
      5'd27: val = 33'sd5;
      5'd28: val = 33'sd3;
      5'd29: val = 33'sd1;
      5'd30: val = 33'sd1;
      default: val = 33'sd0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/eab_front.sv]
// angle front end: modulo 360, conversion to binary angle, quadrant fold
// depends on eab_pkg
`timescale 1ns / 1ps

module eab_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  eab_pkg::angle_t   ang_i   [eab_pkg::NUM_ANGLES],
  output logic              vld_o,
  output eab_pkg::lane_t    lanes_o [eab_pkg::NUM_ANGLES]
);

  localparam int N = eab_pkg::NUM_ANGLES;

  logic [eab_pkg::FRONT_STAGES-1:0] vld_q;

  logic signed [eab_pkg::ANG_W:0]    ext_w  [N];
  logic signed [eab_pkg::ANG_W:0]    wrap_w [N];
  logic [eab_pkg::RECIP_W-1:0]       prod_w [N];
  logic [eab_pkg::RED_W-1:0]         red_d  [N];
  logic [eab_pkg::RED_W-1:0]         red_q  [N];
  logic [eab_pkg::QUO_W-1:0]         quo_d  [N];
  logic [eab_pkg::QUO_W-1:0]         quo_q  [N];
  logic [eab_pkg::RED_W-1:0]         mul_w  [N];
  logic [eab_pkg::RED_W-1:0]         diff_w [N];
  logic [eab_pkg::REM_W-1:0]         rem_w  [N];
  logic [eab_pkg::REM_W-1:0]         half_w [N];
  logic [eab_pkg::FRAC_W-1:0]        frac_w [N];
  logic [eab_pkg::BAM_W-1:0]         bam_d  [N];
  logic [eab_pkg::BAM_W-1:0]         bam_q  [N];
  logic signed [eab_pkg::Z_W-1:0]    t_w    [N];
  eab_pkg::lane_t                    lanes_d [N];
  eab_pkg::lane_t                    lanes_q [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      // reduce to one turn
      ext_w[k] = (eab_pkg::ANG_W + 1)'($signed(ang_i[k]));
      if (ext_w[k] < 0) begin
        wrap_w[k] = ext_w[k] + eab_pkg::TURN_UNITS;
        if (wrap_w[k] < 0) begin
          wrap_w[k] = wrap_w[k] + eab_pkg::TURN_UNITS;
        end
      end else if (ext_w[k] >= eab_pkg::TURN_UNITS) begin
        wrap_w[k] = ext_w[k] - eab_pkg::TURN_UNITS;
      end else begin
        wrap_w[k] = ext_w[k];
      end
      red_d[k]  = wrap_w[k][eab_pkg::RED_W-1:0];
      // quotient by 45 through a reciprocal
      prod_w[k] = eab_pkg::RECIP_W'(red_d[k]) * eab_pkg::RECIP_W'(eab_pkg::RECIP_MUL);
      quo_d[k]  = prod_w[k][eab_pkg::RECIP_SHIFT +: eab_pkg::QUO_W];

      mul_w[k]  = eab_pkg::RED_W'(quo_q[k]) * eab_pkg::SUB_DIV;
      diff_w[k] = red_q[k] - mul_w[k];
      rem_w[k]  = diff_w[k][eab_pkg::REM_W-1:0];
      half_w[k] = (rem_w[k] + eab_pkg::REM_W'(1)) >> 1;
      frac_w[k] = eab_pkg::FRAC_W'(rem_w[k]) * eab_pkg::FRAC_STEP
                + eab_pkg::FRAC_W'(half_w[k]);
      bam_d[k]  = {quo_q[k], frac_w[k]};

      // fold into [-90, 90] degrees
      lanes_d[k].x = eab_pkg::INV_GAIN;
      lanes_d[k].y = '0;
      t_w[k] = $signed({bam_q[k][eab_pkg::BAM_W-1], bam_q[k]});
      priority if (t_w[k] > eab_pkg::QUARTER_TURN) begin
        lanes_d[k].z    = t_w[k] - eab_pkg::HALF_TURN;
        lanes_d[k].flip = 1'b1;
      end else if (t_w[k] < -eab_pkg::QUARTER_TURN) begin
        lanes_d[k].z    = t_w[k] + eab_pkg::HALF_TURN;
        lanes_d[k].flip = 1'b1;
      end else begin
        lanes_d[k].z    = t_w[k];
        lanes_d[k].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[eab_pkg::FRONT_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    quo_q   <= quo_d;
    bam_q   <= bam_d;
    lanes_q <= lanes_d;
  end

  assign vld_o   = vld_q[eab_pkg::FRONT_STAGES-1];
  assign lanes_o = lanes_q;

endmodule

[hw/rtl/eab_cell.sv]
// one cordic rotation step for all three angles
// depends on eab_pkg
`timescale 1ns / 1ps

module eab_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  eab_pkg::lane_t  lanes_i [eab_pkg::NUM_ANGLES],
  output logic            vld_o,
  output eab_pkg::lane_t  lanes_o [eab_pkg::NUM_ANGLES]
);

  localparam int N = eab_pkg::NUM_ANGLES;
  localparam logic signed [eab_pkg::Z_W-1:0] ATAN = eab_pkg::atan_at(5'(IDX));

  logic signed [eab_pkg::XY_W-1:0] x_w  [N];
  logic signed [eab_pkg::XY_W-1:0] y_w  [N];
  logic signed [eab_pkg::XY_W-1:0] dx_w [N];
  logic signed [eab_pkg::XY_W-1:0] dy_w [N];
  eab_pkg::lane_t                  lanes_d [N];
  eab_pkg::lane_t                  lanes_q [N];
  logic                            vld_q;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      x_w[k]  = lanes_i[k].x;
      y_w[k]  = lanes_i[k].y;
      dx_w[k] = y_w[k] >>> IDX;
      dy_w[k] = x_w[k] >>> IDX;
      lanes_d[k].flip = lanes_i[k].flip;
      if (!lanes_i[k].z[eab_pkg::Z_W-1]) begin
        lanes_d[k].x = x_w[k] - dx_w[k];
        lanes_d[k].y = y_w[k] + dy_w[k];
        lanes_d[k].z = lanes_i[k].z - ATAN;
      end else begin
        lanes_d[k].x = x_w[k] + dx_w[k];
        lanes_d[k].y = y_w[k] - dy_w[k];
        lanes_d[k].z = lanes_i[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign vld_o   = vld_q;
  assign lanes_o = lanes_q;

endmodule

[hw/rtl/eab_basis.sv]
// sine/cosine saturation, product tree and output rounding
// depends on eab_pkg
`timescale 1ns / 1ps

module eab_basis #(
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  input  eab_pkg::lane_t                  lanes_i [eab_pkg::NUM_ANGLES],
  output logic                            vld_o,
  output logic signed [OUT_FRAC_BITS+1:0] vec_o   [9]
);

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int N  = eab_pkg::NUM_ANGLES;
  localparam int PW = eab_pkg::PROD_W;
  localparam int RND_SHIFT = 60 - OUT_FRAC_BITS;
  localparam logic signed [PW-1:0] OUT_HALF  = PW'(1) <<< (59 - OUT_FRAC_BITS);
  localparam logic signed [PW-1:0] OUT_LIM   = PW'(1) <<< OUT_FRAC_BITS;
  localparam logic signed [PW-1:0] Q30_HALF  = PW'(1) <<< 29;
  localparam logic signed [eab_pkg::XY_W-1:0] XY_ONE = eab_pkg::XY_W'(eab_pkg::Q30_ONE);

  // two-factor product slots
  localparam int P_CPCY = 0;
  localparam int P_CPSY = 1;
  localparam int P_CRSY = 2;
  localparam int P_CRCY = 3;
  localparam int P_SRSY = 4;
  localparam int P_SRCY = 5;
  localparam int P_SRCP = 6;
  localparam int P_CRCP = 7;
  localparam int NUM_TWO = 8;
  // three-factor product slots
  localparam int T_SRSP_CY = 0;
  localparam int T_SRSP_SY = 1;
  localparam int T_CRSP_CY = 2;
  localparam int T_CRSP_SY = 3;
  localparam int NUM_THREE = 4;

  function automatic eab_pkg::trig_t sat_q30(input logic signed [eab_pkg::XY_W-1:0] v,
                                             input logic flip);
    logic signed [eab_pkg::XY_W-1:0] c;
    if (v > XY_ONE) begin
      c = XY_ONE;
    end else if (v < -XY_ONE) begin
      c = -XY_ONE;
    end else begin
      c = v;
    end
    if (flip) begin
      c = -c;
    end
    return c[eab_pkg::TRIG_W-1:0];
  endfunction

  function automatic logic signed [OW-1:0] to_out(input logic signed [PW-1:0] q);
    logic signed [PW-1:0] v;
    v = (q + OUT_HALF) >>> RND_SHIFT;
    if (v > OUT_LIM) begin
      v = OUT_LIM;
    end else if (v < -OUT_LIM) begin
      v = -OUT_LIM;
    end
    return v[OW-1:0];
  endfunction

  logic [eab_pkg::BASIS_STAGES-1:0] vld_q;

  eab_pkg::trig_t sin_d [N];
  eab_pkg::trig_t cos_d [N];
  eab_pkg::trig_t sin_q [N];
  eab_pkg::trig_t cos_q [N];

  logic signed [PW-1:0] two_d   [NUM_TWO];
  logic signed [PW-1:0] two1_q  [NUM_TWO];
  logic signed [PW-1:0] two2_q  [NUM_TWO];
  logic signed [PW-1:0] two3_q  [NUM_TWO];
  logic signed [PW-1:0] srsp_d, crsp_d, srsp_q, crsp_q;
  eab_pkg::trig_t       srsp_rnd_d, crsp_rnd_d, srsp_rnd_q, crsp_rnd_q;
  eab_pkg::trig_t       sp1_q, sy1_q, cy1_q, sp2_q, sy2_q, cy2_q, sp3_q;
  logic signed [PW-1:0] three_d [NUM_THREE];
  logic signed [PW-1:0] three_q [NUM_THREE];
  logic signed [PW-1:0] sum_d   [9];
  logic signed [PW-1:0] sum_q   [9];
  logic signed [OW-1:0] out_d   [9];
  logic signed [OW-1:0] out_q   [9];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sin_d[k] = sat_q30(lanes_i[k].y, lanes_i[k].flip);
      cos_d[k] = sat_q30(lanes_i[k].x, lanes_i[k].flip);
    end
  end

  // stage 1: two-factor products
  always_comb begin
    two_d[P_CPCY] = PW'(cos_q[eab_pkg::LANE_PITCH]) * PW'(cos_q[eab_pkg::LANE_YAW]);
    two_d[P_CPSY] = PW'(cos_q[eab_pkg::LANE_PITCH]) * PW'(sin_q[eab_pkg::LANE_YAW]);
    two_d[P_CRSY] = PW'(cos_q[eab_pkg::LANE_ROLL])  * PW'(sin_q[eab_pkg::LANE_YAW]);
    two_d[P_CRCY] = PW'(cos_q[eab_pkg::LANE_ROLL])  * PW'(cos_q[eab_pkg::LANE_YAW]);
    two_d[P_SRSY] = PW'(sin_q[eab_pkg::LANE_ROLL])  * PW'(sin_q[eab_pkg::LANE_YAW]);
    two_d[P_SRCY] = PW'(sin_q[eab_pkg::LANE_ROLL])  * PW'(cos_q[eab_pkg::LANE_YAW]);
    two_d[P_SRCP] = PW'(sin_q[eab_pkg::LANE_ROLL])  * PW'(cos_q[eab_pkg::LANE_PITCH]);
    two_d[P_CRCP] = PW'(cos_q[eab_pkg::LANE_ROLL])  * PW'(cos_q[eab_pkg::LANE_PITCH]);
    srsp_d        = PW'(sin_q[eab_pkg::LANE_ROLL])  * PW'(sin_q[eab_pkg::LANE_PITCH]);
    crsp_d        = PW'(cos_q[eab_pkg::LANE_ROLL])  * PW'(sin_q[eab_pkg::LANE_PITCH]);
  end

  // stage 2: back to q30, stage 3: third factor
  always_comb begin
    srsp_rnd_d = eab_pkg::TRIG_W'((srsp_q + Q30_HALF) >>> 30);
    crsp_rnd_d = eab_pkg::TRIG_W'((crsp_q + Q30_HALF) >>> 30);
    three_d[T_SRSP_CY] = PW'(srsp_rnd_q) * PW'(cy2_q);
    three_d[T_SRSP_SY] = PW'(srsp_rnd_q) * PW'(sy2_q);
    three_d[T_CRSP_CY] = PW'(crsp_rnd_q) * PW'(cy2_q);
    three_d[T_CRSP_SY] = PW'(crsp_rnd_q) * PW'(sy2_q);
  end

  // stage 4: sums in q60, stage 5: output rounding
  always_comb begin
    sum_d[0] = two3_q[P_CPCY];
    sum_d[1] = two3_q[P_CPSY];
    sum_d[2] = -(PW'(sp3_q) <<< 30);
    sum_d[3] = two3_q[P_CRSY] - three_q[T_SRSP_CY];
    sum_d[4] = -three_q[T_SRSP_SY] - two3_q[P_CRCY];
    sum_d[5] = -two3_q[P_SRCP];
    sum_d[6] = three_q[T_CRSP_CY] + two3_q[P_SRSY];
    sum_d[7] = three_q[T_CRSP_SY] - two3_q[P_SRCY];
    sum_d[8] = two3_q[P_CRCP];
    for (int k = 0; k < 9; k++) begin
      out_d[k] = to_out(sum_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[eab_pkg::BASIS_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q      <= sin_d;
    cos_q      <= cos_d;
    two1_q     <= two_d;
    srsp_q     <= srsp_d;
    crsp_q     <= crsp_d;
    sp1_q      <= sin_q[eab_pkg::LANE_PITCH];
    sy1_q      <= sin_q[eab_pkg::LANE_YAW];
    cy1_q      <= cos_q[eab_pkg::LANE_YAW];
    two2_q     <= two1_q;
    srsp_rnd_q <= srsp_rnd_d;
    crsp_rnd_q <= crsp_rnd_d;
    sp2_q      <= sp1_q;
    sy2_q      <= sy1_q;
    cy2_q      <= cy1_q;
    two3_q     <= two2_q;
    three_q    <= three_d;
    sp3_q      <= sp2_q;
    sum_q      <= sum_d;
    out_q      <= out_d;
  end

  assign vld_o = vld_q[eab_pkg::BASIS_STAGES-1];
  assign vec_o = out_q;

endmodule

[hw/rtl/euler_angles_to_basis_vectors.sv]
// top level: euler angles to forward, right and up basis vectors
// depends on eab_pkg, eab_front, eab_cell, eab_basis and the macros header
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_macros.svh"

// Usage
//   A beat of pitch, yaw and roll (signed, 1/64 degree) is taken at a rising
//   edge where start is high and busy is low. busy stays low: the datapath is
//   a plain pipeline and takes a new beat every clock cycle.
//   Each beat produces one result beat: the nine Q1.OUT_FRAC_BITS components
//   of the forward, right and up vectors, shown for exactly one cycle with
//   done_o high.
//   A beat passes through angle reduction in the front end, one cordic cell
//   per stage for all three angles at once, then saturation, products, sums
//   and output rounding.
//   Throughput is one beat per cycle, set by the row of cordic cells and the
//   product pipeline, each of which takes a new beat every cycle.
//   Reset clears every valid bit, so no result beat appears until a start
//   beat has gone through the whole pipeline.
//   The receiver cannot stall; a result beat is lost if it is not taken in
//   the cycle that done_o marks it.
module euler_angles_to_basis_vectors #(
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = eab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [15:0]              pitch_deg_i,
  input  logic signed [15:0]              yaw_deg_i,
  input  logic signed [15:0]              roll_deg_i,
  output logic                            done_o,
  output logic signed [OUT_FRAC_BITS+1:0] fwd_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] fwd_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] fwd_z_o,
  output logic signed [OUT_FRAC_BITS+1:0] rgt_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] rgt_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] rgt_z_o,
  output logic signed [OUT_FRAC_BITS+1:0] upv_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] upv_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] upv_z_o
);

  eab_pkg::angle_t ang [eab_pkg::NUM_ANGLES];
  logic            in_vld;

  logic            chain_vld   [CORDIC_STAGES+1];
  eab_pkg::lane_t  chain_lanes [CORDIC_STAGES+1][eab_pkg::NUM_ANGLES];

  logic signed [OUT_FRAC_BITS+1:0] vec [9];

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  assign ang[eab_pkg::LANE_PITCH] = pitch_deg_i;
  assign ang[eab_pkg::LANE_YAW]   = yaw_deg_i;
  assign ang[eab_pkg::LANE_ROLL]  = roll_deg_i;

  eab_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_vld),
    .ang_i   (ang),
    .vld_o   (chain_vld[0]),
    .lanes_o (chain_lanes[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    eab_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (chain_vld[g]),
      .lanes_i (chain_lanes[g]),
      .vld_o   (chain_vld[g+1]),
      .lanes_o (chain_lanes[g+1])
    );
  end

  eab_basis #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_basis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (chain_vld[CORDIC_STAGES]),
    .lanes_i (chain_lanes[CORDIC_STAGES]),
    .vld_o   (done_o),
    .vec_o   (vec)
  );

  assign fwd_x_o = vec[0];
  assign fwd_y_o = vec[1];
  assign fwd_z_o = vec[2];
  assign rgt_x_o = vec[3];
  assign rgt_y_o = vec[4];
  assign rgt_z_o = vec[5];
  assign upv_x_o = vec[6];
  assign upv_y_o = vec[7];
  assign upv_z_o = vec[8];

  `EAB_ASSERT_IMP(a_done_follows_start, clk_i, rst_ni, done_o, $past(start && !busy, CORDIC_STAGES + eab_pkg::FIXED_LATENCY), "result beat without a matching start beat")
  `EAB_ASSERT_IMP(a_fwd_in_range, clk_i, rst_ni, done_o, (fwd_x_o <= (1 <<< OUT_FRAC_BITS)) && (fwd_x_o >= -(1 <<< OUT_FRAC_BITS)) && (fwd_z_o <= (1 <<< OUT_FRAC_BITS)) && (fwd_z_o >= -(1 <<< OUT_FRAC_BITS)), "forward component beyond unit magnitude")
  `EAB_ASSERT_NEVER(a_z_in_range, clk_i, rst_ni, done_o && ((rgt_z_o > (1 <<< OUT_FRAC_BITS)) || (rgt_z_o < -(1 <<< OUT_FRAC_BITS)) || (upv_z_o > (1 <<< OUT_FRAC_BITS)) || (upv_z_o < -(1 <<< OUT_FRAC_BITS))), "right or up z component beyond unit magnitude")

endmodule
